/* sv/arpr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpr_pkg: shared types and constants of the ARP request responder
// Request and result payload structs, the job record between front and back,
// verdict and register codes, and the fixed ARP header bytes.
// ----------------------------------------------------------------------------
package arpr_pkg;

	localparam int unsigned ARP_LEN     = 28;
	localparam int unsigned CNT_W       = 5;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned MAC_W       = 48;
	localparam int unsigned IP_W        = 32;
	localparam int unsigned CFG_W       = 48;

	// verdict codes
	localparam logic [1:0] VERDICT_HANDLED  = 2'd0;
	localparam logic [1:0] VERDICT_DROPPED  = 2'd1;
	localparam logic [1:0] VERDICT_DEFERRED = 2'd2;

	// result kinds
	localparam logic KIND_REPLY   = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// register indexes
	localparam logic REG_LOCAL_IP  = 1'b0;
	localparam logic REG_LOCAL_MAC = 1'b1;

	// reset values of the registers
	localparam logic [IP_W-1:0]  LOCAL_IP_RESET  = 32'h0A18_0001;
	localparam logic [MAC_W-1:0] LOCAL_MAC_RESET = '0;

	// ARP operation written into the reply
	localparam logic [7:0] OPER_REPLY_LO = 8'h02;

	typedef struct packed {
		logic [7:0]       frame_byte;
		logic             frame_end;
		logic [MAC_W-1:0] source_mac;
		logic             tx_busy;
	} in_t;

	typedef struct packed {
		logic       item_kind;
		logic [7:0] reply_byte;
		logic [1:0] verdict;
		logic       last;
	} out_t;

	// one finished frame, handed from the front to the back
	typedef struct packed {
		logic [1:0]       verdict;
		logic [MAC_W-1:0] sender_hw_addr;
		logic [IP_W-1:0]  sender_proto_addr;
	} job_t;

	// expected request header: htype 1, ptype 0x0800, hlen 6, plen 4, oper 1
	function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
		logic [7:0] b;
		unique case (idx)
			3'd0:    b = 8'h00;
			3'd1:    b = 8'h01;
			3'd2:    b = 8'h08;
			3'd3:    b = 8'h00;
			3'd4:    b = 8'h06;
			3'd5:    b = 8'h04;
			3'd6:    b = 8'h00;
			default: b = 8'h01;
		endcase
		return b;
	endfunction

endpackage

/* sv/arp_request_responder_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arp_request_responder_core: ARP request responder for Ethernet / IPv4
// Checks incoming ARP requests and streams the reply and a frame verdict.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid / in_ready / in_data): one ARP payload byte per
//   request, padding included, with frame_end on the last byte, the frame's
//   Ethernet source address and the transmitter busy flag. Bytes are taken one
//   per cycle; in_ready drops only while the two-entry job queue is full.
//   Result channel (out_valid / out_ready / out_data): a handled frame gives
//   28 reply bytes then a verdict with last set; a dropped or deferred frame
//   gives the verdict alone.
//   A frame's job passes the queue and the current-job register, then the output register.
//   Throughput: one result per cycle from the reply generator while out_ready is
//   high, with no gap between queued frames; one request per cycle on the parser side while in_ready is high.
//   Reset clears the parser, the queue and the output stage, and loads the
//   register defaults (local_ip 10.24.0.1, local_mac 0).
//   A stalled receiver holds the output register; the parser keeps taking
//   bytes until the queue holds two finished frames.
//   Configuration: cfg_we with cfg_index 0 (local_ip) or 1 (local_mac), write
//   only while no frame is in flight.
// ----------------------------------------------------------------------------
module arp_request_responder_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  arpr_pkg::in_t               in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output arpr_pkg::out_t              out_data,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [arpr_pkg::CFG_W-1:0]  cfg_data
);

	logic [arpr_pkg::IP_W-1:0]  local_ip_q;
	logic [arpr_pkg::MAC_W-1:0] local_mac_q;

	logic           q_full, q_not_empty, push, pop;
	arpr_pkg::job_t push_job, q_head;

	// register file: hold values between writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q  <= arpr_pkg::LOCAL_IP_RESET;
			local_mac_q <= arpr_pkg::LOCAL_MAC_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				arpr_pkg::REG_LOCAL_IP:  local_ip_q  <= cfg_data[arpr_pkg::IP_W-1:0];
				arpr_pkg::REG_LOCAL_MAC: local_mac_q <= cfg_data[arpr_pkg::MAC_W-1:0];
				default:                 local_ip_q  <= local_ip_q;
			endcase
		end
	end

	// front: parse bytes, push one job per frame
	arpr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.local_ip (local_ip_q),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	// decouple parser from reply generator
	arpr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// back: stream reply bytes and verdict
	arpr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.pop         (pop),
		.local_ip    (local_ip_q),
		.local_mac   (local_mac_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

endmodule

/* sv/arpr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpr_front: request parser
// Absorbs ARP payload bytes, runs the header, sender and target checks and
// pushes one job with its verdict into the queue at frame end.
// ----------------------------------------------------------------------------
module arpr_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  arpr_pkg::in_t              in_data,
	input  logic [arpr_pkg::IP_W-1:0]  local_ip,
	input  logic                       q_full,
	output logic                       push,
	output arpr_pkg::job_t             push_job
);

	logic [arpr_pkg::CNT_W-1:0]  byte_count_q, cnt_n;
	logic                        header_ok_q, hdr_n;
	logic                        smac_ok_q, smac_n;
	logic                        tip_ok_q, tip_n;
	logic [arpr_pkg::MAC_W-1:0]  sha_q, sha_n;
	logic [arpr_pkg::IP_W-1:0]   spa_q, spa_n;
	logic                        accept;
	logic [2:0]                  mac_k;
	logic [7:0]                  src_b, ip_b;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	assign mac_k = 3'(byte_count_q - 5'd8);
	assign src_b = in_data.source_mac[{3'(3'd5 - mac_k), 3'b000} +: 8];
	assign ip_b  = local_ip[{2'(2'd3 - byte_count_q[1:0]), 3'b000} +: 8];

	always_comb begin
		cnt_n  = byte_count_q;
		hdr_n  = header_ok_q;
		smac_n = smac_ok_q;
		tip_n  = tip_ok_q;
		sha_n  = sha_q;
		spa_n  = spa_q;
		if (byte_count_q < arpr_pkg::CNT_W'(arpr_pkg::ARP_LEN)) begin
			cnt_n = byte_count_q + 5'd1;
			priority if (byte_count_q < 5'd8) begin
				if (in_data.frame_byte != arpr_pkg::hdr_byte(byte_count_q[2:0]))
					hdr_n = 1'b0;
			end else if (byte_count_q < 5'd14) begin
				sha_n = {sha_q[arpr_pkg::MAC_W-9:0], in_data.frame_byte};
				if (in_data.frame_byte != src_b)
					smac_n = 1'b0;
			end else if (byte_count_q < 5'd18) begin
				spa_n = {spa_q[arpr_pkg::IP_W-9:0], in_data.frame_byte};
			end else begin
				// target MAC bytes pass unchecked; only the target IP counts
				if (byte_count_q >= 5'd24 && in_data.frame_byte != ip_b)
					tip_n = 1'b0;
			end
		end
	end

	// verdict from the state that includes this byte
	always_comb begin
		push                       = accept && in_data.frame_end;
		push_job.sender_hw_addr    = sha_n;
		push_job.sender_proto_addr = spa_n;
		priority if (cnt_n < arpr_pkg::CNT_W'(arpr_pkg::ARP_LEN) || !hdr_n || !smac_n || !tip_n)
			push_job.verdict = arpr_pkg::VERDICT_DROPPED;
		else if (in_data.tx_busy)
			push_job.verdict = arpr_pkg::VERDICT_DEFERRED;
		else
			push_job.verdict = arpr_pkg::VERDICT_HANDLED;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			header_ok_q  <= 1'b1;
			smac_ok_q    <= 1'b1;
			tip_ok_q     <= 1'b1;
			sha_q        <= '0;
			spa_q        <= '0;
		end else if (accept) begin
			if (in_data.frame_end) begin
				// clear for the next frame
				byte_count_q <= '0;
				header_ok_q  <= 1'b1;
				smac_ok_q    <= 1'b1;
				tip_ok_q     <= 1'b1;
				sha_q        <= '0;
				spa_q        <= '0;
			end else begin
				byte_count_q <= cnt_n;
				header_ok_q  <= hdr_n;
				smac_ok_q    <= smac_n;
				tip_ok_q     <= tip_n;
				sha_q        <= sha_n;
				spa_q        <= spa_n;
			end
		end
	end

endmodule

/* sv/arpr_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpr_queue: job FIFO between parser and reply generator
// Small register FIFO so the parser and the reply generator stall apart.
// ----------------------------------------------------------------------------
module arpr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  arpr_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output arpr_pkg::job_t head
);

	localparam int unsigned PTR_W = $clog2(arpr_pkg::QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(arpr_pkg::QUEUE_DEPTH + 1);

	arpr_pkg::job_t   mem_q [arpr_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full      = (count_q == CNT_W'(arpr_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(arpr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(arpr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* sv/arpr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpr_back: reply generator
// Pops jobs, streams the 28 reply bytes of a handled frame and then the
// verdict through a registered output stage.
// ----------------------------------------------------------------------------
module arpr_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_not_empty,
	input  arpr_pkg::job_t             q_head,
	output logic                       pop,
	input  logic [arpr_pkg::IP_W-1:0]  local_ip,
	input  logic [arpr_pkg::MAC_W-1:0] local_mac,
	output logic                       out_valid,
	input  logic                       out_ready,
	output arpr_pkg::out_t             out_data
);

	localparam logic [arpr_pkg::CNT_W-1:0] LAST_IDX = arpr_pkg::CNT_W'(arpr_pkg::ARP_LEN);

	arpr_pkg::job_t               cur_q;
	logic                         cur_v_q;
	logic [arpr_pkg::CNT_W-1:0]   idx_q;
	logic                         out_valid_q;
	arpr_pkg::out_t               out_q;

	logic                         advance, at_verdict, load_next;
	logic [8*arpr_pkg::ARP_LEN-1:0] reply_vec;
	logic [7:0]                   reply_b;
	arpr_pkg::out_t               item;

	// reply laid out big-endian: header with oper 2, local pair, requester pair
	assign reply_vec = {8'h00, 8'h01, 8'h08, 8'h00, 8'h06, 8'h04, 8'h00,
		arpr_pkg::OPER_REPLY_LO, local_mac, local_ip,
		cur_q.sender_hw_addr, cur_q.sender_proto_addr};
	assign reply_b   = reply_vec[{5'(5'd27 - idx_q), 3'b000} +: 8];

	assign at_verdict = (idx_q == LAST_IDX);
	assign advance    = cur_v_q && (!out_valid_q || out_ready);
	assign load_next  = !cur_v_q || (advance && at_verdict);
	assign pop        = load_next && q_not_empty;

	always_comb begin
		if (at_verdict) begin
			item.item_kind  = arpr_pkg::KIND_VERDICT;
			item.reply_byte = 8'h00;
			item.verdict    = cur_q.verdict;
			item.last       = 1'b1;
		end else begin
			item.item_kind  = arpr_pkg::KIND_REPLY;
			item.reply_byte = reply_b;
			item.verdict    = arpr_pkg::VERDICT_HANDLED;
			item.last       = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= q_head;
		if (advance)
			out_q <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q     <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_next) begin
				cur_v_q <= q_not_empty;
				// skip straight to the verdict when no reply goes out
				idx_q   <= (q_head.verdict == arpr_pkg::VERDICT_HANDLED) ? '0 : LAST_IDX;
			end else if (advance) begin
				idx_q <= idx_q + 1'b1;
			end
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
